// ===== sv/scp_pkg.sv =====
// shared types, command codes and constants of the sump command parser
package scp_pkg;

	localparam int ADDR_W = 5;
	localparam int IDX_W  = 5;

	// register indexes on the configuration port
	localparam logic [2:0] REG_MAX_RATE   = 3'd0;
	localparam logic [2:0] REG_MIN_RATE   = 3'd1;
	localparam logic [2:0] REG_MIN_COUNT  = 3'd2;
	localparam logic [2:0] REG_MAX_COUNT  = 3'd3;
	localparam logic [2:0] REG_CHAN_COUNT = 3'd4;

	localparam logic [30:0] RST_MAX_RATE   = 31'd40000000;
	localparam logic [30:0] RST_MIN_RATE   = 31'd5000;
	localparam logic [30:0] RST_MIN_COUNT  = 31'd100;
	localparam logic [30:0] RST_MAX_COUNT  = 31'd65536;
	localparam logic [4:0]  RST_CHAN_COUNT = 5'd8;

	// host command codes
	localparam logic [7:0] CMD_ARM        = 8'h01;
	localparam logic [7:0] CMD_QUERY      = 8'h02;
	localparam logic [7:0] CMD_METADATA   = 8'h04;
	localparam logic [7:0] CMD_DIVIDER    = 8'h80;
	localparam logic [7:0] CMD_READ_DELAY = 8'h81;
	localparam logic [7:0] CMD_READ_BIG   = 8'h83;
	localparam logic [7:0] CMD_TRIG_MASK  = 8'hC0;
	localparam logic [7:0] CMD_TRIG_VALUE = 8'hC1;

	// metadata keys
	localparam logic [7:0] MD_NAME    = 8'h01;
	localparam logic [7:0] MD_VERSION = 8'h02;
	localparam logic [7:0] MD_MEMORY  = 8'h21;
	localparam logic [7:0] MD_RATE    = 8'h23;
	localparam logic [7:0] MD_PROBES  = 8'h40;
	localparam logic [7:0] MD_PROTO   = 8'h41;
	localparam logic [7:0] MD_PROTO_V = 8'h02;
	localparam logic [7:0] MD_END     = 8'h00;

	localparam logic [IDX_W-1:0] QUERY_LEN = 5'd4;
	localparam logic [IDX_W-1:0] META_LEN  = 5'd28;
	localparam logic [2:0]       ARG_BYTES = 3'd4;

	localparam logic signed [4:0] TRIG_NONE = -5'sd1;

	typedef logic [7:0] byte_t;

	// controller to datapath
	typedef struct packed {
		logic             take;
		logic             div_start;
		logic             load_byte;
		logic             load_arm;
		logic             meta_sel;
		logic             last;
		logic [IDX_W-1:0] idx;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_query;
		logic start_meta;
		logic start_arm;
		logic div_busy;
	} dp_stat_t;

	function automatic logic is_long(input byte_t b);
		logic r;
		r = 1'b0;
		if (b[7:2] == 6'b100000)
			r = 1'b1;
		if (b[7:4] == 4'hC && b[1:0] != 2'b11)
			r = 1'b1;
		return r;
	endfunction

	// "1ALS"
	function automatic byte_t query_byte(input logic [1:0] i);
		byte_t r;
		case (i)
			2'd0: r = 8'h31;
			2'd1: r = 8'h41;
			2'd2: r = 8'h4C;
			default: r = 8'h53;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/scp_div.sv =====
// restoring divider, one quotient bit per cycle
module scp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [24:0] divisor,
	output logic        busy,
	output logic [30:0] quotient
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_q;
	logic [30:0] quo_q;
	logic [24:0] dvs_q;
	logic [25:0] trial;
	logic [26:0] diff;

	assign trial = {rem_q, quo_q[30]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd30;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// no borrow: subtract and set the quotient bit
			if (!diff[26])
				rem_q <= diff[24:0];
			else
				rem_q <= trial[24:0];
			quo_q <= {quo_q[29:0], ~diff[26]};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start && cnt_q != 5'd0 |=> busy_q && cnt_q == $past(cnt_q) - 5'd1)
		else $error("divider step count broken");

endmodule

// ===== sv/scp_dp.sv =====
// datapath: argument collection, trigger and count state, divider, result register
module scp_dp #(
	parameter int TRIGGER_CHANNELS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scp_pkg::ctrl_cmd_t    cmd,
	output scp_pkg::dp_stat_t     stat,
	input  logic [7:0]            rx_byte,
	input  logic [30:0]           max_rate,
	input  logic [30:0]           min_rate,
	input  logic [30:0]           min_sample_count,
	input  logic [30:0]           max_sample_count,
	input  logic [4:0]            channel_count,
	output logic                  kind,
	output logic [7:0]            tx_byte,
	output logic                  last,
	output logic [30:0]           sample_count,
	output logic [30:0]           capture_rate,
	output logic signed [4:0]     trigger_channel,
	output logic                  trigger_rising
);

	localparam int SCAN_LIMIT = (TRIGGER_CHANNELS < 16) ? TRIGGER_CHANNELS : 16;

	logic [2:0]         args_pending_q;
	logic [7:0]         pending_cmd_q;
	logic [31:0]        arg_shift_q;
	logic [15:0]        trig_mask_q;
	logic signed [4:0]  trig_chan_q;
	logic               trig_level_q;
	logic [23:0]        rate_div_q;
	logic [31:0]        read_count_q;

	logic [31:0]        arg_next;
	logic signed [4:0]  scan_chan;
	logic               idle_byte;
	logic               div_busy;
	logic [30:0]        div_quo;
	logic [30:0]        rate_clamped;
	logic [31:0]        mem_size;
	logic [7:0]         probes;
	scp_pkg::byte_t     meta_byte;
	scp_pkg::byte_t     msg_byte;

	logic               kind_q;
	logic [7:0]         tx_q;
	logic               last_q;
	logic [30:0]        cnt_q;
	logic [30:0]        rate_q;
	logic signed [4:0]  chan_q;
	logic               rise_q;

	assign idle_byte = (args_pending_q == 3'd0);
	assign arg_next  = {rx_byte, arg_shift_q[31:8]};

	assign stat.start_query = idle_byte && rx_byte == scp_pkg::CMD_QUERY;
	assign stat.start_meta  = idle_byte && rx_byte == scp_pkg::CMD_METADATA;
	assign stat.start_arm   = idle_byte && rx_byte == scp_pkg::CMD_ARM;
	assign stat.div_busy    = div_busy;

	// lowest set mask bit within the trigger channels
	always_comb begin
		scan_chan = scp_pkg::TRIG_NONE;
		for (int i = 15; i >= 0; i--) begin
			if (i < SCAN_LIMIT && arg_next[i])
				scan_chan = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			args_pending_q <= '0;
			pending_cmd_q  <= '0;
			arg_shift_q    <= '0;
			trig_mask_q    <= '0;
			trig_chan_q    <= scp_pkg::TRIG_NONE;
			trig_level_q   <= 1'b0;
			rate_div_q     <= '0;
			read_count_q   <= '0;
		end else if (cmd.take) begin
			if (!idle_byte) begin
				arg_shift_q    <= arg_next;
				args_pending_q <= args_pending_q - 3'd1;
				if (args_pending_q == 3'd1) begin
					case (pending_cmd_q)
						scp_pkg::CMD_DIVIDER: rate_div_q <= arg_next[23:0];
						scp_pkg::CMD_READ_DELAY: read_count_q <= {16'd0, arg_next[15:0]} + 32'd1;
						scp_pkg::CMD_READ_BIG: read_count_q <= arg_next + 32'd1;
						scp_pkg::CMD_TRIG_MASK: begin
							trig_mask_q <= arg_next[15:0];
							trig_chan_q <= scan_chan;
						end
						scp_pkg::CMD_TRIG_VALUE: begin
							if (trig_mask_q != 16'd0 && !trig_chan_q[4])
								trig_level_q <= arg_next[trig_chan_q[4:0]];
							else
								trig_level_q <= 1'b0;
						end
						default: ;
					endcase
				end
			end else if (scp_pkg::is_long(rx_byte)) begin
				pending_cmd_q  <= rx_byte;
				args_pending_q <= scp_pkg::ARG_BYTES;
				arg_shift_q    <= '0;
			end else if (rx_byte == scp_pkg::CMD_ARM) begin
				// nonpositive count falls back to the minimum
				if (read_count_q == 32'd0 || read_count_q[31])
					read_count_q <= {1'b0, min_sample_count};
			end
		end
	end

	scp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (max_rate),
		.divisor  ({1'b0, rate_div_q} + 25'd1),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// quotient never exceeds the maximum, only the lower clamp applies
	assign rate_clamped = (div_quo < min_rate) ? min_rate : div_quo;

	// channel_count / 8 is 0..3
	always_comb begin
		if (channel_count > 5'd4)
			mem_size = (channel_count[3] ? {1'b0, max_sample_count} : 32'd0)
				+ (channel_count[4] ? {max_sample_count, 1'b0} : 32'd0);
		else
			mem_size = {1'b0, max_sample_count};
		probes = (channel_count > 5'd4) ? {3'd0, channel_count} : 8'd8;
	end

	always_comb begin
		case (cmd.idx)
			5'd0:  meta_byte = scp_pkg::MD_NAME;
			5'd1:  meta_byte = 8'h53;
			5'd2:  meta_byte = 8'h55;
			5'd3:  meta_byte = 8'h4D;
			5'd4:  meta_byte = 8'h50;
			5'd5:  meta_byte = 8'h41;
			5'd6:  meta_byte = 8'h00;
			5'd7:  meta_byte = scp_pkg::MD_VERSION;
			5'd8:  meta_byte = 8'h30;
			5'd9:  meta_byte = 8'h2E;
			5'd10: meta_byte = 8'h30;
			5'd11: meta_byte = 8'h30;
			5'd12: meta_byte = 8'h00;
			5'd13: meta_byte = scp_pkg::MD_MEMORY;
			5'd14: meta_byte = mem_size[31:24];
			5'd15: meta_byte = mem_size[23:16];
			5'd16: meta_byte = mem_size[15:8];
			5'd17: meta_byte = mem_size[7:0];
			5'd18: meta_byte = scp_pkg::MD_RATE;
			5'd19: meta_byte = {1'b0, max_rate[30:24]};
			5'd20: meta_byte = max_rate[23:16];
			5'd21: meta_byte = max_rate[15:8];
			5'd22: meta_byte = max_rate[7:0];
			5'd23: meta_byte = scp_pkg::MD_PROBES;
			5'd24: meta_byte = probes;
			5'd25: meta_byte = scp_pkg::MD_PROTO;
			5'd26: meta_byte = scp_pkg::MD_PROTO_V;
			default: meta_byte = scp_pkg::MD_END;
		endcase
		msg_byte = cmd.meta_sel ? meta_byte : scp_pkg::query_byte(cmd.idx[1:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			kind_q <= 1'b0;
			tx_q   <= msg_byte;
			last_q <= cmd.last;
			cnt_q  <= '0;
			rate_q <= '0;
			chan_q <= '0;
			rise_q <= 1'b0;
		end else if (cmd.load_arm) begin
			kind_q <= 1'b1;
			tx_q   <= '0;
			last_q <= 1'b1;
			cnt_q  <= read_count_q[30:0];
			rate_q <= rate_clamped;
			chan_q <= trig_chan_q;
			rise_q <= trig_level_q;
		end
	end

	assign kind            = kind_q;
	assign tx_byte         = tx_q;
	assign last            = last_q;
	assign sample_count    = cnt_q;
	assign capture_rate    = rate_q;
	assign trigger_channel = chan_q;
	assign trigger_rising  = rise_q;

endmodule

// ===== sv/scp_ctrl.sv =====
// controller: item handshake, reply sequencing and output valid
module scp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  scp_pkg::dp_stat_t  stat,
	output scp_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EMIT = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_ARM  = 2'd3;

	logic [1:0]                  state_q, state_d;
	logic [scp_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic                        meta_q, meta_d;
	logic                        out_valid_q;
	logic                        out_free;
	logic [scp_pkg::IDX_W-1:0]   msg_last;

	assign out_free = !out_valid_q || !out_stall;
	assign msg_last = meta_q ? scp_pkg::META_LEN - 5'd1 : scp_pkg::QUERY_LEN - 5'd1;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		meta_d  = meta_q;
		cmd     = '0;
		cmd.idx = idx_q;
		cmd.meta_sel = meta_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) begin
					if (stat.start_query) begin
						idx_d   = '0;
						meta_d  = 1'b0;
						state_d = S_EMIT;
					end else if (stat.start_meta) begin
						idx_d   = '0;
						meta_d  = 1'b1;
						state_d = S_EMIT;
					end else if (stat.start_arm) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.load_byte = 1'b1;
					cmd.last      = (idx_q == msg_last);
					idx_d         = idx_q + 5'd1;
					if (idx_q == msg_last)
						state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (!stat.div_busy)
					state_d = S_ARM;
			end
			S_ARM: begin
				if (out_free) begin
					cmd.load_arm = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			meta_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			meta_q  <= meta_d;
			if (cmd.load_byte || cmd.load_arm)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(cmd.load_byte || cmd.load_arm))
		else $error("result register overwritten while stalled");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> idx_q <= msg_last)
		else $error("reply index past end of message");

	a_arm_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DIV && stat.div_busy)
		else $error("divider not running after arm");

endmodule

// ===== sv/sump_command_parser.sv =====
// sump command parser: top level with configuration registers
// replies: after a query or metadata item the emit state gives one byte a cycle
//   to the result register (4 and 28 bytes) while the output is not stalled
// arm: the capture-start item is loaded once the 31-step divider has finished
// input: one item at a time; other bytes are taken without a stall
// reset clears the control state and loads the default configuration registers
module sump_command_parser #(
	parameter int TRIGGER_CHANNELS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [7:0]                  tx_byte,
	output logic                        last,
	output logic [30:0]                 sample_count,
	output logic [30:0]                 capture_rate,
	output logic signed [4:0]           trigger_channel,
	output logic                        trigger_rising
);

	logic [30:0]        max_rate_q;
	logic [30:0]        min_rate_q;
	logic [30:0]        min_count_q;
	logic [30:0]        max_count_q;
	logic [4:0]         chan_count_q;
	logic               wr_en;
	logic [2:0]         reg_idx;
	scp_pkg::ctrl_cmd_t cmd;
	scp_pkg::dp_stat_t  stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q   <= scp_pkg::RST_MAX_RATE;
			min_rate_q   <= scp_pkg::RST_MIN_RATE;
			min_count_q  <= scp_pkg::RST_MIN_COUNT;
			max_count_q  <= scp_pkg::RST_MAX_COUNT;
			chan_count_q <= scp_pkg::RST_CHAN_COUNT;
		end else if (wr_en) begin
			unique case (reg_idx)
				scp_pkg::REG_MAX_RATE:   max_rate_q   <= pwdata[30:0];
				scp_pkg::REG_MIN_RATE:   min_rate_q   <= pwdata[30:0];
				scp_pkg::REG_MIN_COUNT:  min_count_q  <= pwdata[30:0];
				scp_pkg::REG_MAX_COUNT:  max_count_q  <= pwdata[30:0];
				scp_pkg::REG_CHAN_COUNT: chan_count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			scp_pkg::REG_MAX_RATE:   prdata = {1'b0, max_rate_q};
			scp_pkg::REG_MIN_RATE:   prdata = {1'b0, min_rate_q};
			scp_pkg::REG_MIN_COUNT:  prdata = {1'b0, min_count_q};
			scp_pkg::REG_MAX_COUNT:  prdata = {1'b0, max_count_q};
			scp_pkg::REG_CHAN_COUNT: prdata = {27'd0, chan_count_q};
			default:                 prdata = 32'd0;
		endcase
	end

	scp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	scp_dp #(
		.TRIGGER_CHANNELS (TRIGGER_CHANNELS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.rx_byte          (rx_byte),
		.max_rate         (max_rate_q),
		.min_rate         (min_rate_q),
		.min_sample_count (min_count_q),
		.max_sample_count (max_count_q),
		.channel_count    (chan_count_q),
		.kind             (kind),
		.tx_byte          (tx_byte),
		.last             (last),
		.sample_count     (sample_count),
		.capture_rate     (capture_rate),
		.trigger_channel  (trigger_channel),
		.trigger_rising   (trigger_rising)
	);

endmodule
